@@ src/lfu_pkg.sv @@
// ----------------------------------------------------------------------------
// lfu_pkg: shared types and constants of the LFU cache policy unit
// Holds the control bundle broadcast to the slot cells and the record that
// the victim search passes along the chain of cells.
// ----------------------------------------------------------------------------
package lfu_pkg;

  localparam int KEY_W  = 32;
  localparam int VAL_W  = 32;
  localparam int CNT_W  = 32;
  // widest slot index or rank the unit supports (1024 slots)
  localparam int SLOT_W = 10;

  localparam logic [VAL_W-1:0] MISS_VALUE = '1;
  localparam logic [CNT_W-1:0] CNT_MAX    = '1;

  localparam logic CMD_GET = 1'b0;
  localparam logic CMD_PUT = 1'b1;

  // broadcast from the controller to every cell
  typedef struct packed {
    logic              close_en;
    logic [SLOT_W-1:0] close_rank;
    logic              upd_en;
    logic [SLOT_W-1:0] upd_idx;
    logic [SLOT_W-1:0] upd_rank;
    logic              upd_write;
    logic              kill_en;
    logic [SLOT_W-1:0] kill_idx;
    logic              load_en;
    logic [SLOT_W-1:0] load_idx;
    logic [SLOT_W-1:0] new_rank;
    logic [KEY_W-1:0]  key;
    logic [VAL_W-1:0]  value;
  } lfu_ctrl_t;

  // running result of the victim and free slot search
  typedef struct packed {
    logic              vld;
    logic [SLOT_W-1:0] idx;
    logic [CNT_W-1:0]  cnt;
    logic [SLOT_W-1:0] rank;
    logic              free_found;
    logic [SLOT_W-1:0] free_idx;
  } lfu_best_t;

endpackage

@@ src/lfu_cell.sv @@
// ----------------------------------------------------------------------------
// lfu_cell: one cache slot
// Stores key, value, use count and recency rank, matches the probe key and
// hands the running victim search record on to the next cell each cycle.
// ----------------------------------------------------------------------------
module lfu_cell import lfu_pkg::*; #(
  parameter int SLOT_ID = 0,
  parameter int RANK_W  = 6
) (
  input  logic              clk,
  input  logic              rst,
  input  lfu_ctrl_t         ctrl,
  output logic              hit,
  output logic [VAL_W-1:0]  hit_value,
  output logic [SLOT_W-1:0] hit_rank,
  input  lfu_best_t         best_in,
  output lfu_best_t         best_out
);

  localparam logic [SLOT_W-1:0] MY_ID = SLOT_W'(SLOT_ID);

  logic              valid;
  logic [KEY_W-1:0]  key;
  logic [VAL_W-1:0]  value;
  logic [CNT_W-1:0]  cnt;
  logic [RANK_W-1:0] rank;
  logic [SLOT_W-1:0] rank_ext;
  logic              own_better;

  assign rank_ext  = SLOT_W'(rank);
  assign hit       = valid && (key == ctrl.key);
  assign hit_value = hit ? value : '0;
  assign hit_rank  = hit ? rank_ext : '0;

  // keep the lower (count, rank) pair
  assign own_better = valid && (!best_in.vld || (cnt < best_in.cnt) ||
                      ((cnt == best_in.cnt) && (rank_ext < best_in.rank)));

  // advance the search record
  always_ff @(posedge clk) begin
    if (rst) begin
      best_out <= '0;
    end else begin
      best_out.vld  <= best_in.vld | own_better;
      best_out.idx  <= own_better ? MY_ID : best_in.idx;
      best_out.cnt  <= own_better ? cnt : best_in.cnt;
      best_out.rank <= own_better ? rank_ext : best_in.rank;
      best_out.free_found <= best_in.free_found | !valid;
      best_out.free_idx   <= best_in.free_found ? best_in.free_idx : MY_ID;
    end
  end

  // slot contents
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctrl.load_en && ctrl.load_idx == MY_ID) begin
      valid <= 1'b1;
      key   <= ctrl.key;
      value <= ctrl.value;
      cnt   <= CNT_W'(1);
      rank  <= ctrl.new_rank[RANK_W-1:0];
    end else if (ctrl.kill_en && ctrl.kill_idx == MY_ID) begin
      valid <= 1'b0;
    end else if (ctrl.upd_en && ctrl.upd_idx == MY_ID) begin
      rank <= ctrl.upd_rank[RANK_W-1:0];
      if (cnt != CNT_MAX) begin
        cnt <= cnt + 1'b1;
      end
      if (ctrl.upd_write) begin
        value <= ctrl.value;
      end
    end else if (ctrl.close_en && valid && rank_ext > ctrl.close_rank) begin
      rank <= rank - 1'b1;
    end
  end

endmodule

@@ src/lfu_cache_policy_unit.sv @@
// ----------------------------------------------------------------------------
// lfu_cache_policy_unit: fully associative LFU cache, LRU tie break
// A get or put transaction is taken when start is high and busy is low; its
// result appears for one cycle with done high and cannot be stalled. A get,
// a put that hits, and a put while the capacity is zero go through accept,
// key match and update. A put of an absent key also runs the victim search
// down the chain of MAX_ENTRIES cells, one cell per cycle, then commits.
// The user must write the capacity register through cfg_valid/cfg_data only
// while idle, which the unit does not enforce; cfg_ready is always high.
// ----------------------------------------------------------------------------
module lfu_cache_policy_unit import lfu_pkg::*; #(
  parameter int MAX_ENTRIES = 64
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  logic                    cmd,
  input  logic signed [KEY_W-1:0] key,
  input  logic signed [VAL_W-1:0] value,
  output logic                    done,
  output logic                    found,
  output logic signed [VAL_W-1:0] read_value,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [6:0]              cfg_data
);

  localparam int RANK_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int HELD_W = $clog2(MAX_ENTRIES + 1);
  localparam int SCAN_W = $clog2(MAX_ENTRIES + 1);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_LOOK   = 3'd1;
  localparam logic [2:0] ST_DECIDE = 3'd2;
  localparam logic [2:0] ST_SCAN   = 3'd3;
  localparam logic [2:0] ST_COMMIT = 3'd4;

  logic [2:0]        state;
  logic [SCAN_W-1:0] scan_cnt;
  logic              cmd_q;
  logic [KEY_W-1:0]  key_q;
  logic [VAL_W-1:0]  value_q;
  logic              hit_q;
  logic [SLOT_W-1:0] hit_idx_q;
  logic [SLOT_W-1:0] hit_rank_q;
  logic [VAL_W-1:0]  hit_val_q;
  logic [HELD_W-1:0] held;
  logic [6:0]        capacity;

  lfu_ctrl_t         ctrl;
  lfu_best_t         chain [MAX_ENTRIES+1];
  logic              hit_v  [MAX_ENTRIES];
  logic [VAL_W-1:0]  hval_v [MAX_ENTRIES];
  logic [SLOT_W-1:0] hrank_v[MAX_ENTRIES];

  logic              any_hit;
  logic [SLOT_W-1:0] any_idx;
  logic [SLOT_W-1:0] any_rank;
  logic [VAL_W-1:0]  any_val;
  logic              cap_zero;
  logic              full;
  logic              evict;
  logic              insert;
  logic [SLOT_W-1:0] ins_idx;
  lfu_best_t         best;

  assign busy      = (state != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign chain[0]  = '0;
  assign best      = chain[MAX_ENTRIES];

  // chain of slot cells
  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    lfu_cell #(.SLOT_ID(i), .RANK_W(RANK_W)) u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (ctrl),
      .hit       (hit_v[i]),
      .hit_value (hval_v[i]),
      .hit_rank  (hrank_v[i]),
      .best_in   (chain[i]),
      .best_out  (chain[i+1])
    );
  end

  // merge the single matching slot
  always_comb begin
    any_hit  = 1'b0;
    any_idx  = '0;
    any_rank = '0;
    any_val  = '0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      any_hit  = any_hit | hit_v[i];
      any_idx  = any_idx | (hit_v[i] ? SLOT_W'(i) : '0);
      any_rank = any_rank | hrank_v[i];
      any_val  = any_val | hval_v[i];
    end
  end

  // capacity checks and insertion slot
  assign cap_zero = (capacity == '0);
  assign full     = (32'(held) >= 32'(capacity)) || (32'(held) >= MAX_ENTRIES);
  assign evict    = full && (held != '0) && best.vld;
  always_comb begin
    ins_idx = best.free_idx;
    if (evict && (!best.free_found || best.idx < best.free_idx)) begin
      ins_idx = best.idx;
    end
  end
  assign insert = evict || best.free_found;

  // cell commands
  always_comb begin
    ctrl           = '0;
    ctrl.key       = key_q;
    ctrl.value     = value_q;
    ctrl.upd_idx   = hit_idx_q;
    ctrl.upd_rank  = SLOT_W'(held - 1'b1);
    ctrl.upd_write = (cmd_q == CMD_PUT);
    ctrl.kill_idx  = best.idx;
    ctrl.load_idx  = ins_idx;
    ctrl.new_rank  = evict ? SLOT_W'(held - 1'b1) : SLOT_W'(held);
    ctrl.close_rank = hit_rank_q;
    if (state == ST_DECIDE && hit_q && !(cmd_q == CMD_PUT && cap_zero)) begin
      ctrl.upd_en   = 1'b1;
      ctrl.close_en = 1'b1;
    end
    if (state == ST_COMMIT) begin
      ctrl.close_rank = best.rank;
      ctrl.close_en   = evict;
      ctrl.kill_en    = evict;
      ctrl.load_en    = insert;
    end
  end

  // capacity register
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= 7'd64;
    end else if (cfg_valid && cfg_ready) begin
      capacity <= cfg_data;
    end
  end

  // transaction sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      scan_cnt <= '0;
      held     <= '0;
      done     <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          done <= 1'b0;
          if (start) begin
            cmd_q   <= cmd;
            key_q   <= key;
            value_q <= value;
            state   <= ST_LOOK;
          end
        end
        ST_LOOK: begin
          done       <= 1'b0;
          hit_q      <= any_hit;
          hit_idx_q  <= any_idx;
          hit_rank_q <= any_rank;
          hit_val_q  <= any_val;
          state      <= ST_DECIDE;
        end
        ST_DECIDE: begin
          if (cmd_q == CMD_PUT && !hit_q && !cap_zero) begin
            done     <= 1'b0;
            scan_cnt <= '0;
            state    <= ST_SCAN;
          end else begin
            done       <= 1'b1;
            found      <= hit_q;
            read_value <= (cmd_q == CMD_GET && hit_q) ? hit_val_q : MISS_VALUE;
            state      <= ST_IDLE;
          end
        end
        ST_SCAN: begin
          done     <= 1'b0;
          scan_cnt <= scan_cnt + 1'b1;
          if (scan_cnt == SCAN_W'(MAX_ENTRIES - 1)) begin
            state <= ST_COMMIT;
          end
        end
        ST_COMMIT: begin
          held       <= held - HELD_W'(evict) + HELD_W'(insert);
          done       <= 1'b1;
          found      <= 1'b0;
          read_value <= MISS_VALUE;
          state      <= ST_IDLE;
        end
        default: begin
          done  <= 1'b0;
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

@@ tb/sv/lfu_cache_policy_unit_tb.sv @@
// ----------------------------------------------------------------------------
// lfu_cache_policy_unit_tb: self-checking bench for the LFU cache policy unit
// Drives get/put transactions from a queue at the falling edge and predicts
// each result with a behavioural copy of the cache: LFU victim, LRU tie
// break, capacity clamp. Results are checked in order at the rising edge over
// several capacity settings and sender idle rates.
// ----------------------------------------------------------------------------
module lfu_cache_policy_unit_tb import lfu_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS      = 64;
  localparam int DRAIN_WAIT = SLOTS + 12;
  localparam int WD_LIMIT   = 20000;

  typedef struct {
    logic        op;
    logic [31:0] k;
    logic [31:0] v;
  } cache_req_t;

  typedef struct {
    logic        hit;
    logic [31:0] data;
  } cache_rsp_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  logic              busy;
  logic              cmd = CMD_GET;
  logic signed [31:0] key = '0;
  logic signed [31:0] value = '0;
  logic              done;
  logic              found;
  logic signed [31:0] read_value;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [6:0]        cfg_data = '0;

  cache_req_t req_q[$];
  cache_rsp_t rsp_q[$];
  int idle_pct = 0;
  int n_errors = 0, n_sent = 0, n_hits = 0, n_rsp = 0, wd_count = 0;

  // cache copy used for prediction
  bit          m_valid[SLOTS];
  bit [31:0]   m_key[SLOTS], m_val[SLOTS], m_cnt[SLOTS];
  int          m_rank[SLOTS];
  int          m_held = 0;
  int          m_cap = 64;

  lfu_cache_policy_unit #(.MAX_ENTRIES(SLOTS)) DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd), .key(key),
    .value(value), .done(done), .found(found), .read_value(read_value),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  // drop rank r from the recency order
  function automatic void squeeze_rank(input int r);
    for (int i = 0; i < SLOTS; i++)
      if (m_valid[i] && m_rank[i] > r) m_rank[i]--;
  endfunction

  function automatic void mark_used(input int s);
    squeeze_rank(m_rank[s]);
    m_rank[s] = m_held - 1;
    if (m_cnt[s] != 32'hFFFF_FFFF) m_cnt[s]++;
  endfunction

  function automatic cache_rsp_t cache_access(input cache_req_t r);
    cache_rsp_t res;
    int s, vic, lim;
    s = -1;
    vic = -1;
    lim = (m_cap > SLOTS) ? SLOTS : m_cap;
    for (int i = 0; i < SLOTS; i++)
      if (s < 0 && m_valid[i] && m_key[i] == r.k) s = i;
    res.hit = (s >= 0);
    res.data = MISS_VALUE;
    if (r.op == CMD_GET) begin
      if (s >= 0) begin
        res.data = m_val[s];
        mark_used(s);
      end
      return res;
    end
    if (lim == 0) return res;
    if (s >= 0) begin
      m_val[s] = r.v;
      mark_used(s);
      return res;
    end
    // evict the least used, least recently touched entry when full
    if (m_held >= lim && m_held > 0) begin
      for (int i = 0; i < SLOTS; i++)
        if (m_valid[i] && (vic < 0 || m_cnt[i] < m_cnt[vic] ||
            (m_cnt[i] == m_cnt[vic] && m_rank[i] < m_rank[vic]))) vic = i;
      m_valid[vic] = 1'b0;
      squeeze_rank(m_rank[vic]);
      m_held--;
    end
    for (int i = 0; i < SLOTS; i++)
      if (!m_valid[i]) begin
        m_valid[i] = 1'b1;
        m_key[i] = r.k;
        m_val[i] = r.v;
        m_cnt[i] = 1;
        m_rank[i] = m_held;
        m_held++;
        break;
      end
    return res;
  endfunction

  // drive: hold the transaction until taken, then load the next or idle
  always @(negedge clk) begin
    if (!rst && (!start || !busy)) begin
      if (req_q.size() > 0 && $urandom_range(99) >= idle_pct) begin
        cache_req_t r;
        r = req_q[0];
        req_q.delete(0);
        cmd <= r.op;
        key <= r.k;
        value <= r.v;
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor: predict on acceptance, check on done, watch for a hang
  always @(posedge clk) begin
    if (!rst) begin
      cache_rsp_t e;
      cache_req_t r;
      wd_count <= ((start && !busy) || done) ? 0 : wd_count + 1;
      if (start && !busy) begin
        r.op = cmd;
        r.k = key;
        r.v = value;
        e = cache_access(r);
        rsp_q.insert(rsp_q.size(), e);
        n_sent <= n_sent + 1;
      end
      if (done) begin
        n_rsp <= n_rsp + 1;
        if (rsp_q.size() == 0) begin
          n_errors++;
          if (n_errors <= 10) $display("unexpected result: found=%0b data=%h", found,
                                       read_value);
        end else begin
          e = rsp_q[0];
          rsp_q.delete(0);
          if (e.hit) n_hits <= n_hits + 1;
          if (found !== e.hit || read_value !== e.data) begin
            n_errors++;
            if (n_errors <= 10)
              $display("mismatch: found exp %0b got %0b, data exp %h got %h",
                       e.hit, found, e.data, read_value);
          end
        end
      end
      if (wd_count >= WD_LIMIT) begin
        $display("watchdog expired: %0d results outstanding", rsp_q.size());
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // keys from a small pool so hits occur, scrambled to exercise every bit
  function automatic logic [31:0] pick_key(input int pool);
    if ($urandom_range(9) == 0) return $urandom;
    return $urandom_range(pool) * 32'h9E37_79B1;
  endfunction

  task automatic wait_idle();
    wait (req_q.size() == 0 && !start && rsp_q.size() == 0);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_capacity(input int c);
    wait_idle();
    @(negedge clk);
    cfg_data <= c[6:0];
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    m_cap = c;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic void push_req(input logic op, input logic [31:0] k,
                                   input logic [31:0] v);
    cache_req_t r;
    r.op = op;
    r.k = k;
    r.v = v;
    req_q.insert(req_q.size(), r);
  endfunction

  initial begin
    int caps[8] = '{64, 3, 1, 0, 127, 10, 2, 64};
    int idles[8] = '{0, 81, 0, 38, 81, 0, 38, 0};
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: extremes, miss, insert, hit, overwrite, eviction, capacity zero
    push_req(CMD_GET, 32'h8000_0000, 32'h0);
    push_req(CMD_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
    push_req(CMD_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
    push_req(CMD_PUT, 32'h0, 32'hFFFF_FFFF);
    push_req(CMD_PUT, 32'hFFFF_FFFF, 32'h0);
    push_req(CMD_GET, 32'h8000_0000, 32'h1234);
    push_req(CMD_GET, 32'h7FFF_FFFF, 32'h0);
    push_req(CMD_GET, 32'h0, 32'h0);
    push_req(CMD_GET, 32'hFFFF_FFFF, 32'h0);
    push_req(CMD_PUT, 32'h0, 32'h5555_AAAA);
    push_req(CMD_GET, 32'h0, 32'h0);
    write_capacity(2);
    push_req(CMD_PUT, 32'h1, 32'h11);
    push_req(CMD_PUT, 32'h2, 32'h22);
    push_req(CMD_GET, 32'h2, 32'h0);
    push_req(CMD_PUT, 32'h3, 32'h33);
    push_req(CMD_GET, 32'h1, 32'h0);
    push_req(CMD_GET, 32'h0, 32'h0);
    write_capacity(0);
    push_req(CMD_PUT, 32'h4, 32'h44);
    push_req(CMD_PUT, 32'h0, 32'h99);
    push_req(CMD_GET, 32'h0, 32'h0);
    push_req(CMD_GET, 32'h4, 32'h0);

    // random phases over capacity and sender idle rate
    for (int p = 0; p < 8; p++) begin
      int pool;
      write_capacity(caps[p]);
      idle_pct = idles[p];
      pool = (caps[p] > 16) ? 90 : 12;
      for (int i = 0; i < 160; i++)
        push_req($urandom_range(1) ? CMD_PUT : CMD_GET, pick_key(pool), $urandom);
    end

    wait_idle();
    $display("covered %0d transactions, %0d hits, capacities 0 to 127", n_sent, n_hits);
    $display("%0d mismatches", n_errors);
    if (n_errors == 0 && rsp_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

@@ files.f @@
src/lfu_pkg.sv
src/lfu_cell.sv
src/lfu_cache_policy_unit.sv
tb/sv/lfu_cache_policy_unit_tb.sv
